>>> hdl/pedal_plausibility_torque_top_assert.svh
// Assertion macros used by the pedal plausibility top level.
`ifndef PEDAL_PLAUSIBILITY_TORQUE_TOP_ASSERT_SVH
`define PEDAL_PLAUSIBILITY_TORQUE_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PPT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pedal plausibility check failed");

// Next-cycle implication, checked out of reset.
`define PPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pedal plausibility check failed");

`endif

>>> hdl/ppt_pkg.sv
// Shared constants, widths and types of the pedal plausibility block.
package ppt_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int FRACTION_BITS = 12;
    localparam int GAIN_BITS     = 16;
    localparam int TORQUE_W      = 15;
    localparam int PM_OUT_W      = 13;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 16;

    localparam int GAIN_SHIFT     = 24 - FRACTION_BITS;
    localparam int FULL_SCALE     = 1 << FRACTION_BITS;
    localparam int DIFF_W         = SAMPLE_BITS + 1;
    localparam int PROD_W         = DIFF_W + GAIN_BITS + 1;
    localparam int Q_W            = PROD_W - GAIN_SHIFT;
    localparam int OOR_W          = Q_W + 3;
    localparam int SUM_W          = Q_W + 1;
    localparam int CMP_W          = SUM_W + 4;
    localparam int PM_W           = Q_W + 10;
    localparam int TS_W           = FRACTION_BITS + 2;
    localparam int TP_W           = TS_W + TORQUE_W;
    localparam int PERMILLE_SCALE = 1000;
    localparam int PERMILLE_LIMIT = 4000;

    // -0.20 and 1.25 of full scale, compared as q*5 and q*4
    localparam logic signed [OOR_W-1:0] OOR_LOW  = OOR_W'(-FULL_SCALE);
    localparam logic signed [OOR_W-1:0] OOR_HIGH = OOR_W'(5 * FULL_SCALE);

    localparam logic [CFG_INDEX_W-1:0] CFG_PEDAL1_OFFSET   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PEDAL1_GAIN     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PEDAL2_OFFSET   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PEDAL2_GAIN     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BRAKE_THRESHOLD = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_TORQUE      = 3'd5;

    typedef enum logic [1:0] {
        FAULT_NONE     = 2'd0,
        FAULT_RANGE    = 2'd1,
        FAULT_DISAGREE = 2'd2,
        FAULT_BRAKE    = 2'd3
    } fault_code_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_SEL,
        ST_SCALE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic norm_en;
        logic sel_en;
        logic scale_en;
        logic commit;
        logic range_bad;
    } lane_ctrl_t;

endpackage

>>> hdl/pedal_plausibility_torque_top.sv
// Top level of the accelerator pedal plausibility check and torque request.
//
// One transaction per control tick: two pedal samples, brake sample, start
// button and motor controller fault come in on s_*, one result goes out on
// m_*. Ready-to-drive latches on an accepted start press (both pedals at or
// below rest, brake at or above threshold, no controller fault) and clears
// only on reset. Two pedal lanes normalize in parallel to Q12
// ((sample - offset) * gain >> 12, floor), and a merge stage picks the fault
// (sticky brake, out of range, disagreement, brake overlap) and the torque.
// The four-step sequencer (normalize multiply, range/clamp, permille and
// torque multiply, output load) holds one transaction at a time and waits
// in output load while a full result is not taken; the next transaction
// is taken in the same cycle the previous result is loaded. A finished
// result parks in the output register while the next one is processed.
// Config writes are taken at any time but belong in idle periods.
`include "pedal_plausibility_torque_top_assert.svh"

module pedal_plausibility_torque_top
    import ppt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // config write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [39:0]            s_tdata,  // pedal1_sample, pedal2_sample, brake_sample, pad
    input  logic [1:0]             s_tuser,  // button_pressed, controller_fault
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [47:0]            m_tdata,  // torque_request, fault_code, pedal1_permille,
                                             // pedal2_permille, pad
    output logic [2:0]             m_tuser   // drive_ready, buzzer_start, lockout_clear
);

    // config registers
    logic [SAMPLE_BITS-1:0] off1_reg, off2_reg, brake_thr_reg;
    logic [GAIN_BITS-1:0]   gain1_reg, gain2_reg;
    logic [TORQUE_W-1:0]    max_torque_reg;

    // captured transaction
    logic [SAMPLE_BITS-1:0] s1_reg, s2_reg, brake_reg;
    logic [SAMPLE_BITS-1:0] in_s1, in_s2, in_brake;
    logic                   in_button, in_mc_fault;

    // drive state
    logic ready_reg, ready_next;
    logic buzzer_reg, buzzer_next;
    logic lockout_reg, lockout_next;
    logic start_ok;

    state_t state_reg, state_next;
    logic   accept;
    logic   out_free;
    logic   commit;

    lane_ctrl_t                 ctrl;
    logic                       oor1, oor2;
    logic signed [Q_W-1:0]      qsel1, qsel2;
    logic signed [PM_OUT_W-1:0] pm1, pm2;
    fault_code_t                fault;
    logic [TORQUE_W-1:0]        torque;

    // output register
    logic                       m_valid_reg, m_valid_next;
    logic [TORQUE_W-1:0]        o_torque_reg;
    fault_code_t                o_fault_reg;
    logic signed [PM_OUT_W-1:0] o_pm1_reg, o_pm2_reg;
    logic                       o_ready_reg, o_buzzer_reg, o_lockout_reg;

    assign in_s1       = s_tdata[11:0];
    assign in_s2       = s_tdata[23:12];
    assign in_brake    = s_tdata[35:24];
    assign in_button   = s_tuser[0];
    assign in_mc_fault = s_tuser[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off1_reg       <= SAMPLE_BITS'(1193);
            gain1_reg      <= GAIN_BITS'(23400);
            off2_reg       <= SAMPLE_BITS'(1810);
            gain2_reg      <= GAIN_BITS'(23933);
            brake_thr_reg  <= SAMPLE_BITS'(450);
            max_torque_reg <= TORQUE_W'(1000);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PEDAL1_OFFSET:   off1_reg       <= cfg_data[SAMPLE_BITS-1:0];
                CFG_PEDAL1_GAIN:     gain1_reg      <= cfg_data[GAIN_BITS-1:0];
                CFG_PEDAL2_OFFSET:   off2_reg       <= cfg_data[SAMPLE_BITS-1:0];
                CFG_PEDAL2_GAIN:     gain2_reg      <= cfg_data[GAIN_BITS-1:0];
                CFG_BRAKE_THRESHOLD: brake_thr_reg  <= cfg_data[SAMPLE_BITS-1:0];
                CFG_MAX_TORQUE:      max_torque_reg <= cfg_data[TORQUE_W-1:0];
                default:             ;
            endcase
        end
    end

    // start press acceptance, evaluated on the incoming transaction
    assign start_ok = in_button && (in_s1 <= off1_reg) && (in_s2 <= off2_reg) &&
                      (in_brake >= brake_thr_reg) && !in_mc_fault;

    always_comb
    begin
        ready_next   = ready_reg;
        buzzer_next  = buzzer_reg;
        lockout_next = lockout_reg;
        if (accept)
        begin
            buzzer_next  = start_ok && !ready_reg;
            lockout_next = start_ok && ready_reg;
            ready_next   = ready_reg || start_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg   <= 1'b0;
            buzzer_reg  <= 1'b0;
            lockout_reg <= 1'b0;
        end
        else
        begin
            ready_reg   <= ready_next;
            buzzer_reg  <= buzzer_next;
            lockout_reg <= lockout_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg    <= in_s1;
            s2_reg    <= in_s2;
            brake_reg <= in_brake;
        end
    end

    // sequencer
    assign out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        state_next     = state_reg;
        s_tready       = 1'b0;
        commit         = 1'b0;
        ctrl.norm_en   = 1'b0;
        ctrl.sel_en    = 1'b0;
        ctrl.scale_en  = 1'b0;
        ctrl.commit    = 1'b0;
        ctrl.range_bad = oor1 || oor2;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                    state_next = ST_NORM;
            end
            ST_NORM:
            begin
                ctrl.norm_en = 1'b1;
                state_next   = ST_SEL;
            end
            ST_SEL:
            begin
                ctrl.sel_en = 1'b1;
                state_next  = ST_SCALE;
            end
            ST_SCALE:
            begin
                ctrl.scale_en = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    commit      = 1'b1;
                    ctrl.commit = 1'b1;
                    s_tready    = 1'b1;   // next transaction may follow directly
                    state_next  = s_tvalid ? ST_NORM : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    ppt_lane u_lane1 (
        .clk      (clk),
        .ctrl     (ctrl),
        .sample   (s1_reg),
        .offset   (off1_reg),
        .gain     (gain1_reg),
        .oor      (oor1),
        .qsel     (qsel1),
        .permille (pm1)
    );

    ppt_lane u_lane2 (
        .clk      (clk),
        .ctrl     (ctrl),
        .sample   (s2_reg),
        .offset   (off2_reg),
        .gain     (gain2_reg),
        .oor      (oor2),
        .qsel     (qsel2),
        .permille (pm2)
    );

    ppt_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .q1         (qsel1),
        .q2         (qsel2),
        .brake_over (brake_reg > brake_thr_reg),
        .max_torque (max_torque_reg),
        .ready      (ready_reg),
        .fault      (fault),
        .torque     (torque)
    );

    // result register
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (commit)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            o_torque_reg  <= torque;
            o_fault_reg   <= fault;
            o_pm1_reg     <= pm1;
            o_pm2_reg     <= pm2;
            o_ready_reg   <= ready_reg;
            o_buzzer_reg  <= buzzer_reg;
            o_lockout_reg <= lockout_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, o_pm2_reg, o_pm1_reg, o_fault_reg, o_torque_reg};
    assign m_tuser  = {o_lockout_reg, o_buzzer_reg, o_ready_reg};

    // torque only flows with no fault and the car ready
    `PPT_ASSERT_SAME(a_torque_gated, clk, rst_n, m_tvalid && (m_tdata[14:0] != '0), (m_tdata[16:15] == FAULT_NONE) && m_tuser[0])
    // buzzer and lockout pulses are exclusive
    `PPT_ASSERT_SAME(a_pulse_excl, clk, rst_n, m_tvalid, !(m_tuser[1] && m_tuser[2]))
    // one transaction in flight at a time
    `PPT_ASSERT_NEXT(a_single_flight, clk, rst_n, s_tvalid && s_tready, !s_tready)
    // ready-to-drive never drops outside reset
    `PPT_ASSERT_NEXT(a_ready_sticky, clk, rst_n, ready_reg, ready_reg)

endmodule

>>> hdl/ppt_lane.sv
// One pedal lane: normalization, range flag, clamp and permille scaling.
module ppt_lane
    import ppt_pkg::*;
(
    input  logic                       clk,
    input  lane_ctrl_t                 ctrl,
    input  logic [SAMPLE_BITS-1:0]     sample,
    input  logic [SAMPLE_BITS-1:0]     offset,
    input  logic [GAIN_BITS-1:0]       gain,
    output logic                       oor,
    output logic signed [Q_W-1:0]      qsel,
    output logic signed [PM_OUT_W-1:0] permille
);

    logic signed [DIFF_W-1:0]         diff;
    logic signed [PROD_W-1:0]         prod;
    logic signed [Q_W-1:0]            q_reg;
    logic signed [Q_W-1:0]            q_clamped;
    logic signed [Q_W-1:0]            qsel_reg;
    logic signed [OOR_W-1:0]          q_ext;
    logic [Q_W-1:0]                   mag;
    logic [PM_W-1:0]                  pm_reg;
    logic                             neg_reg;
    logic [PM_W-FRACTION_BITS-1:0]    pm_int;
    logic [PM_OUT_W-1:0]              pm_sat;

    assign diff = $signed({1'b0, sample}) - $signed({1'b0, offset});
    assign prod = diff * $signed({1'b0, gain});

    // range check on the raw fraction
    assign q_ext = OOR_W'(q_reg);
    assign oor   = (q_ext * OOR_W'(5) < OOR_LOW) || (q_ext * OOR_W'(4) > OOR_HIGH);

    always_comb
    begin
        if (q_reg < 0)
            q_clamped = '0;
        else if (q_reg > Q_W'(FULL_SCALE))
            q_clamped = Q_W'(FULL_SCALE);
        else
            q_clamped = q_reg;
    end

    assign mag = qsel_reg[Q_W-1] ? Q_W'(-qsel_reg) : qsel_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.norm_en)
            q_reg <= prod[PROD_W-1:GAIN_SHIFT];   // floor shift
        if (ctrl.sel_en)
            qsel_reg <= ctrl.range_bad ? q_reg : q_clamped;
        if (ctrl.scale_en)
        begin
            pm_reg  <= PM_W'(mag) * PM_W'(PERMILLE_SCALE);
            neg_reg <= qsel_reg[Q_W-1];
        end
    end

    assign pm_int = pm_reg[PM_W-1:FRACTION_BITS];
    assign pm_sat = (pm_int > (PM_W-FRACTION_BITS)'(PERMILLE_LIMIT)) ?
                    PM_OUT_W'(PERMILLE_LIMIT) : pm_int[PM_OUT_W-1:0];

    assign qsel     = qsel_reg;
    assign permille = neg_reg ? -$signed(pm_sat) : $signed(pm_sat);

endmodule

>>> hdl/ppt_merge.sv
// Merge stage: fault selection across both lanes and the torque product.
module ppt_merge
    import ppt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lane_ctrl_t             ctrl,
    input  logic signed [Q_W-1:0]  q1,
    input  logic signed [Q_W-1:0]  q2,
    input  logic                   brake_over,
    input  logic [TORQUE_W-1:0]    max_torque,
    input  logic                   ready,
    output fault_code_t            fault,
    output logic [TORQUE_W-1:0]    torque
);

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] diff_abs;
    logic signed [CMP_W-1:0] sum_ext;
    logic signed [CMP_W-1:0] diff_ext;
    logic                    hot_tenth;
    fault_code_t             fault_next;
    fault_code_t             fault_reg;
    fault_code_t             prev_fault_reg;
    logic [TP_W-1:0]         tprod_reg;

    assign sum      = SUM_W'(q1) + SUM_W'(q2);
    assign diff_abs = (q1 > q2) ? SUM_W'(q1) - SUM_W'(q2) : SUM_W'(q2) - SUM_W'(q1);
    assign sum_ext  = CMP_W'(sum);
    assign diff_ext = CMP_W'(diff_abs);

    assign hot_tenth = sum_ext * CMP_W'(10) > CMP_W'(FULL_SCALE);

    always_comb
    begin
        // sticky brake fault wins, then range, disagreement, brake overlap
        if (prev_fault_reg == FAULT_BRAKE && hot_tenth)
            fault_next = FAULT_BRAKE;
        else if (ctrl.range_bad)
            fault_next = FAULT_RANGE;
        else if (diff_ext * CMP_W'(10) > CMP_W'(FULL_SCALE))
            fault_next = FAULT_DISAGREE;
        else if (sum_ext * CMP_W'(2) > CMP_W'(FULL_SCALE) && brake_over)
            fault_next = FAULT_BRAKE;
        else
            fault_next = FAULT_NONE;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.scale_en)
        begin
            fault_reg <= fault_next;
            // sum is within 0..2*full scale whenever torque is used
            tprod_reg <= TP_W'(sum[TS_W-1:0]) * TP_W'(max_torque);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_fault_reg <= FAULT_NONE;
        else if (ctrl.commit)
            prev_fault_reg <= fault_reg;
    end

    assign fault  = fault_reg;
    assign torque = (fault_reg == FAULT_NONE && ready) ?
                    tprod_reg[FRACTION_BITS+1 +: TORQUE_W] : '0;

endmodule
